// ===== src/cmsn_pkg.sv =====
package cmsn_pkg;

    localparam int NumCellsDefault = 1024;
    localparam int NumTypesDefault = 16;
    localparam int SumWidthDefault = 48;

    localparam int CellW  = 10;
    localparam int TypeW  = 4;
    localparam int CompW  = 16;
    localparam int CountW = 16;
    localparam int MaskW  = 16;
    localparam int MagW   = 64;

    localparam logic OP_ACCUM   = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [CellW-1:0]  cell_index;
        logic [TypeW-1:0]  material_type;
        logic signed [CompW-1:0] spin_x;
        logic signed [CompW-1:0] spin_y;
        logic signed [CompW-1:0] spin_z;
        logic [CompW-1:0]  moment;
    } cmsn_in_t;

    typedef struct packed {
        logic [CellW-1:0]  out_cell;
        logic signed [CompW-1:0] dir_x;
        logic signed [CompW-1:0] dir_y;
        logic signed [CompW-1:0] dir_z;
        logic [CompW-1:0]  mag_ratio;
        logic              cell_empty;
        logic              zero_length;
    } cmsn_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ACC_RD, ST_ACC_WR, ST_RO_RD, ST_RO_MAG,
        ST_RO_SHIFT, ST_RO_SQUARE, ST_RO_SQRT, ST_RO_DIV, ST_RO_DONE
    } cmsn_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear_step;
        logic rd;
        logic acc_wr;
        logic mag;
        logic shift_step;
        logic square_step;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic ro_wr;
        logic emit;
    } cmsn_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic shift_done;
        logic square_done;
        logic sqrt_done;
        logic div_done;
        logic skip;
    } cmsn_stat_t;

endpackage

// ===== src/cmsn_ctrl.sv =====
module cmsn_ctrl
    import cmsn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       opcode,
    input  cmsn_stat_t stat,
    output cmsn_cmd_t  cmd,
    output logic       busy
);

    cmsn_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (opcode == OP_READOUT) ? ST_RO_RD : ST_ACC_RD;
                end
            end
            ST_ACC_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                cmd.acc_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RO_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_RO_MAG;
            end
            ST_RO_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = ST_RO_SHIFT;
            end
            ST_RO_SHIFT:
            begin
                if (stat.skip)
                begin
                    state_next = ST_RO_DONE;
                end
                else if (stat.shift_done)
                begin
                    state_next = ST_RO_SQUARE;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            ST_RO_SQUARE:
            begin
                cmd.square_step = 1'b1;
                if (stat.square_done)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = ST_RO_SQRT;
                end
            end
            ST_RO_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_done)
                begin
                    cmd.sqrt_step = 1'b0;
                    cmd.div_init  = 1'b1;
                    state_next    = ST_RO_DIV;
                end
            end
            ST_RO_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_step = 1'b0;
                    state_next   = ST_RO_DONE;
                end
            end
            ST_RO_DONE:
            begin
                cmd.ro_wr  = 1'b1;
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !busy)
        else $error("readout did not return to idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && start) |=> busy)
        else $error("accepted transaction did not raise busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_wr |-> $past(cmd.rd))
        else $error("accumulate write without read");

endmodule

// ===== src/cmsn_dp.sv =====
module cmsn_dp
    import cmsn_pkg::*;
#(
    parameter int CELL_COUNT = NumCellsDefault,
    parameter int NUM_TYPES  = NumTypesDefault,
    parameter int SUM_WIDTH  = SumWidthDefault
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmsn_cmd_t        cmd,
    input  cmsn_in_t         item,
    input  logic [MaskW-1:0] mask,
    output cmsn_stat_t       stat,
    output logic             res_valid,
    output cmsn_out_t        res
);

    localparam int AW   = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int RowW = 4 * SUM_WIDTH + CountW;
    localparam int ProdW = CompW + CompW + 1;

    logic [RowW-1:0] mem [CELL_COUNT];

    cmsn_in_t        it_reg;
    logic [RowW-1:0] row_reg;
    logic [AW:0]     clr_reg;
    logic            ovr;
    logic [AW-1:0]   addr;
    logic [RowW-1:0] wdata;
    logic            we;

    assign ovr  = {{(32-CellW){1'b0}}, it_reg.cell_index} >= CELL_COUNT;
    assign addr = cmd.clear_step ? clr_reg[AW-1:0] : AW'(it_reg.cell_index);
    assign stat.clear_done = clr_reg == (AW+1)'(CELL_COUNT - 1);

    // Row fields.
    logic [SUM_WIDTH-1:0] rx, ry, rz, rm;
    logic [CountW-1:0]    rc;
    assign {rx, ry, rz, rm, rc} = row_reg;

    // Accumulate.
    logic signed [ProdW-1:0] px, py, pz;
    logic                    magn;
    logic [RowW-1:0]         acc_row;
    assign magn = ({{(32-TypeW){1'b0}}, it_reg.material_type} < NUM_TYPES)
                  && !mask[it_reg.material_type];
    assign px = $signed({it_reg.spin_x}) * $signed({1'b0, it_reg.moment});
    assign py = $signed({it_reg.spin_y}) * $signed({1'b0, it_reg.moment});
    assign pz = $signed({it_reg.spin_z}) * $signed({1'b0, it_reg.moment});

    always_comb
    begin
        acc_row = row_reg;
        acc_row[CountW-1:0] = (rc == '1) ? rc : rc + 1'b1;
        if (magn)
        begin
            acc_row[RowW-1 -: SUM_WIDTH] = rx + SUM_WIDTH'(px);
            acc_row[RowW-1-SUM_WIDTH -: SUM_WIDTH] = ry + SUM_WIDTH'(py);
            acc_row[RowW-1-2*SUM_WIDTH -: SUM_WIDTH] = rz + SUM_WIDTH'(pz);
            acc_row[CountW +: SUM_WIDTH] = rm + SUM_WIDTH'(it_reg.moment);
        end
    end

    assign we    = cmd.clear_step || (cmd.acc_wr && !ovr) || (cmd.ro_wr && !ovr);
    assign wdata = cmd.acc_wr ? acc_row : '0;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            row_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step && !stat.clear_done)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_reg <= item;
        end
    end

    // Readout: magnitudes, normalising shift, squares, root, divisions.
    logic [SUM_WIDTH-1:0] ax_reg, ay_reg, az_reg, or_reg;
    logic                 nx_reg, ny_reg, nz_reg, empty_reg;
    logic [6:0]           s_reg;

    function automatic logic [SUM_WIDTH-1:0] mag_of(input logic [SUM_WIDTH-1:0] v);
        mag_of = v[SUM_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    assign stat.skip = empty_reg;
    assign stat.shift_done = (or_reg >> 31) == '0;

    // Sum of squares, one square per cycle.
    logic [1:0]  sq_cnt_reg;
    logic [63:0] ssum_reg;
    logic [31:0] sq_op;
    assign sq_op = (sq_cnt_reg == 2'd0) ? ax_reg[31:0] :
                   (sq_cnt_reg == 2'd1) ? ay_reg[31:0] : az_reg[31:0];
    assign stat.square_done = sq_cnt_reg == 2'd2;

    // Bit-pair square root.
    logic [63:0] sq_v_reg, sq_res_reg, sq_bit_reg;
    assign stat.sqrt_done = sq_bit_reg == '0;
    logic [63:0] len;
    assign len = sq_res_reg;
    logic zero_len;
    assign zero_len = len == '0;

    // Four restoring dividers sharing one step control, one quotient bit a cycle.
    // Directions: (a*65536 + len) / (2*len), 18 quotient bits suffice.
    // Ratio: (len << s) / m then half-up from remainder; 17 bits plus round.
    logic [6:0]  dv_cnt_reg;
    logic [63:0] dr_reg [3];
    logic [17:0] dq_reg [3];
    logic [63:0] dn_reg [3];
    logic [SUM_WIDTH+1:0] mr_reg;
    logic [17:0] mq_reg;
    logic [127:0] mn_reg;
    logic        msat_reg;
    assign stat.div_done = dv_cnt_reg == 7'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            empty_reg <= 1'b0;
        end
        if (cmd.mag)
        begin
            ax_reg    <= mag_of(rx);
            ay_reg    <= mag_of(ry);
            az_reg    <= mag_of(rz);
            nx_reg    <= rx[SUM_WIDTH-1];
            ny_reg    <= ry[SUM_WIDTH-1];
            nz_reg    <= rz[SUM_WIDTH-1];
            or_reg    <= mag_of(rx) | mag_of(ry) | mag_of(rz);
            s_reg     <= '0;
            empty_reg <= ovr || (rc == '0);
            sq_cnt_reg <= '0;
            ssum_reg   <= '0;
        end
        if (cmd.shift_step)
        begin
            ax_reg <= ax_reg >> 1;
            ay_reg <= ay_reg >> 1;
            az_reg <= az_reg >> 1;
            or_reg <= or_reg >> 1;
            s_reg  <= s_reg + 1'b1;
        end
        if (cmd.square_step)
        begin
            ssum_reg   <= ssum_reg + sq_op * sq_op;
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
        if (cmd.sqrt_init)
        begin
            sq_v_reg   <= ssum_reg + az_reg[31:0] * az_reg[31:0];
            sq_res_reg <= '0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end
        if (cmd.sqrt_step)
        begin
            if (sq_v_reg >= sq_res_reg + sq_bit_reg)
            begin
                sq_v_reg   <= sq_v_reg - (sq_res_reg + sq_bit_reg);
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.div_init)
        begin
            dv_cnt_reg <= 7'd96;
            dn_reg[0]  <= {ax_reg[31:0], 16'd0} + len;
            dn_reg[1]  <= {ay_reg[31:0], 16'd0} + len;
            dn_reg[2]  <= {az_reg[31:0], 16'd0} + len;
            for (int k = 0; k < 3; k++)
            begin
                dr_reg[k] <= '0;
                dq_reg[k] <= '0;
            end
            mn_reg   <= 128'(len[31:0]) << s_reg;
            mr_reg   <= '0;
            mq_reg   <= '0;
            msat_reg <= 1'b0;
        end
        if (cmd.div_step)
        begin
            dv_cnt_reg <= dv_cnt_reg - 1'b1;
            if (dv_cnt_reg <= 7'd64)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if ({dr_reg[k][62:0], dn_reg[k][63]} >= {len[62:0], 1'b0})
                    begin
                        dr_reg[k] <= {dr_reg[k][62:0], dn_reg[k][63]} - {len[62:0], 1'b0};
                        dq_reg[k] <= {dq_reg[k][16:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg[k] <= {dr_reg[k][62:0], dn_reg[k][63]};
                        dq_reg[k] <= {dq_reg[k][16:0], 1'b0};
                    end
                    dn_reg[k] <= {dn_reg[k][62:0], 1'b0};
                end
            end
            if ({mr_reg[SUM_WIDTH:0], mn_reg[95]} >= {2'b0, rm})
            begin
                mr_reg <= {mr_reg[SUM_WIDTH:0], mn_reg[95]} - {2'b0, rm};
                mq_reg <= {mq_reg[16:0], 1'b1};
                if (mq_reg > 18'd16383)
                begin
                    msat_reg <= 1'b1;
                end
            end
            else
            begin
                mr_reg <= {mr_reg[SUM_WIDTH:0], mn_reg[95]};
                mq_reg <= {mq_reg[16:0], 1'b0};
                if (mq_reg > 18'd16384)
                begin
                    msat_reg <= 1'b1;
                end
            end
            mn_reg <= {mn_reg[126:0], 1'b0};
        end
    end

    function automatic logic [CompW-1:0] dir_of(input logic [17:0] d, input logic neg);
        if (!neg)
        begin
            dir_of = (d > 18'd32767) ? 16'd32767 : d[15:0];
        end
        else
        begin
            dir_of = 16'(18'd65536 - d);
        end
    endfunction

    logic [SUM_WIDTH+1:0] rem2;
    logic [17:0]          mq_rnd;
    cmsn_out_t            res_next;
    assign rem2   = {mr_reg[SUM_WIDTH:0], 1'b0};
    assign mq_rnd = mq_reg + ((rem2 >= {2'b0, rm}) ? 18'd1 : 18'd0);

    always_comb
    begin
        res_next = '0;
        res_next.out_cell = it_reg.cell_index;
        if (empty_reg)
        begin
            res_next.cell_empty = 1'b1;
        end
        else if (zero_len)
        begin
            res_next.zero_length = 1'b1;
        end
        else
        begin
            res_next.dir_x = dir_of(dq_reg[0], nx_reg);
            res_next.dir_y = dir_of(dq_reg[1], ny_reg);
            res_next.dir_z = dir_of(dq_reg[2], nz_reg);
            res_next.mag_ratio = (rm == '0 || msat_reg || mq_rnd > 18'd32768)
                                 ? 16'd32768 : mq_rnd[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
        end
        else
        begin
            res_valid <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res <= res_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.cell_empty && res.zero_length))
        else $error("both flags raised");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_wr |-> !cmd.clear_step)
        else $error("write port conflict");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.zero_length) |-> (res.mag_ratio == '0))
        else $error("zero length readout not zeroed");

endmodule

// ===== src/cell_moment_sum_normalize_top.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+------------------------
// command   | start / busy           | cmd (cmsn_in_t)
// result    | result_valid strobe    | result (cmsn_out_t)
// config    | cfg_valid / cfg_ready  | cfg_data (type mask)
//
// After reset the block clears its cell memory, one cell a cycle, with busy held
// high. An accumulate keeps busy high after acceptance for a memory read, then a
// read-modify-write. A readout keeps busy high for the memory read, magnitudes,
// up to SUM_WIDTH - 31 normalising shifts, squares, the 32-step square root and
// the 96-step shared dividers; an empty cell skips all past the magnitudes.
// The result is strobed in the first idle cycle and cannot be stalled.
module cell_moment_sum_normalize_top
    import cmsn_pkg::*;
#(
    parameter int CELL_COUNT = NumCellsDefault,
    parameter int NUM_TYPES  = NumTypesDefault,
    parameter int SUM_WIDTH  = SumWidthDefault
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmsn_in_t         cmd,
    output logic             result_valid,
    output cmsn_out_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [MaskW-1:0] cfg_data
);

    cmsn_cmd_t        ctl;
    cmsn_stat_t       stat;
    logic [MaskW-1:0] mask_reg;

    // The mask is always writable; user must write it only while idle (unenforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_valid)
        begin
            mask_reg <= cfg_data;
        end
    end

    cmsn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (cmd.opcode),
        .stat   (stat),
        .cmd    (ctl),
        .busy   (busy)
    );

    cmsn_dp #(
        .CELL_COUNT (CELL_COUNT),
        .NUM_TYPES  (NUM_TYPES),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl),
        .item      (cmd),
        .mask      (mask_reg),
        .stat      (stat),
        .res_valid (result_valid),
        .res       (result)
    );

endmodule
